// ===== design/assert_macros.svh =====
// ----------------------------------------------------------------------------
// Assertion macros
// Helpers for the buffer pool blocks.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication, checked at every rising edge outside reset
`define ASSERT_NOW(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("assertion failed: same-cycle check");

// next-cycle implication
`define ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("assertion failed: next-cycle check");

`endif

// ===== design/bplru_pkg.sv =====
// ----------------------------------------------------------------------------
// Buffer pool LRU manager package
// Command and status codes, field widths and sequencer states.
// ----------------------------------------------------------------------------
package bplru_pkg;

  localparam int CMD_W    = 2;
  localparam int BLK_W    = 13;
  localparam int STATUS_W = 2;
  localparam int SLOT_W   = 5;

  localparam int NUM_BLOCKS = 8192;

  localparam logic [CMD_W-1:0] CMD_ALLOC  = 2'd0;
  localparam logic [CMD_W-1:0] CMD_LOOKUP = 2'd1;
  localparam logic [CMD_W-1:0] CMD_DIRTY  = 2'd2;

  localparam logic [STATUS_W-1:0] ST_OK       = 2'd0;
  localparam logic [STATUS_W-1:0] ST_OOB      = 2'd1;
  localparam logic [STATUS_W-1:0] ST_NOT_HELD = 2'd2;

  typedef enum logic [1:0] {
    S_IDLE,
    S_SCAN,
    S_FINISH
  } state_t;

endpackage

// ===== design/bplru_ram.sv =====
// ----------------------------------------------------------------------------
// Generic RAM
// One write port, one read port with registered read data.
// ----------------------------------------------------------------------------
module bplru_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 32
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// ===== design/buffer_pool_lru_manager.sv =====
// Buffer pool LRU manager. Each request (allocate, look up or mark dirty) is
// served by one sequential sweep over the slot table: tag and age live in two
// RAMs with registered read, and a single age incrementer and comparator
// examine one slot per cycle in S_SCAN. The result is registered in S_FINISH
// once the output register is free, after the sweep, or straight after
// S_IDLE with no sweep for a block number out of range; from S_FINISH the
// block returns to S_IDLE to accept the next request. The block takes no
// new request until the current one has been placed in the output register.
// Valid and dirty bits are flip-flops cleared by reset, so no clearing pass
// is needed.
// ----------------------------------------------------------------------------
// Buffer pool LRU manager
// Slot metadata with aging, free-slot or oldest-slot allocation, lookup and dirty marking.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module buffer_pool_lru_manager #(
  parameter int NUM_SLOTS = 32,
  parameter int AGE_WIDTH = 16
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [15:0] s_tdata,   // [12:0] block_num, [15:13] zero
  input  logic [1:0]  s_tuser,   // [1:0] command
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [23:0] m_tdata    // [1:0] status, [6:2] slot_index,
                                 // [7] writeback_needed, [20:8] writeback_block
);

  localparam int IW = $clog2(NUM_SLOTS);
  localparam int CW = $clog2(NUM_SLOTS + 1);
  localparam int BW = bplru_pkg::BLK_W;

  bplru_pkg::state_t state, state_next;

  logic [bplru_pkg::CMD_W-1:0] cmd;
  logic [BW-1:0]               blk;
  logic                        oob;
  logic [CW-1:0]               idx;
  logic                        p_valid;
  logic [IW-1:0]               p_idx;
  logic                        found_free;
  logic [IW-1:0]               free_idx;
  logic [AGE_WIDTH-1:0]        best_age;
  logic [IW-1:0]               best_idx;
  logic [BW-1:0]               best_tag;
  logic                        hit;
  logic [IW-1:0]               hit_idx;
  logic [NUM_SLOTS-1:0]        slot_valid;
  logic [NUM_SLOTS-1:0]        slot_dirty;

  logic [bplru_pkg::STATUS_W-1:0] out_status;
  logic [bplru_pkg::SLOT_W-1:0]   out_slot;
  logic                           out_wb;
  logic [BW-1:0]                  out_wb_blk;

  logic                 accept;
  logic                 scan_last;
  logic                 out_free;
  logic                 finish;
  logic                 is_alloc;
  logic                 cur_valid;
  logic [AGE_WIDTH-1:0] rd_age;
  logic [BW-1:0]        rd_tag;
  logic [AGE_WIDTH-1:0] aged;
  logic [IW-1:0]        pick;
  logic [IW-1:0]        raddr;
  logic                 age_we;
  logic [IW-1:0]        age_waddr;
  logic [AGE_WIDTH-1:0] age_wdata;
  logic                 tag_we;
  logic                 in_oob;
  logic                 evict_dirty;

  bplru_ram #(.WIDTH(AGE_WIDTH), .DEPTH(NUM_SLOTS)) u_age_ram (
    .clk   (clk),
    .we    (age_we),
    .waddr (age_waddr),
    .wdata (age_wdata),
    .raddr (raddr),
    .rdata (rd_age)
  );

  bplru_ram #(.WIDTH(BW), .DEPTH(NUM_SLOTS)) u_tag_ram (
    .clk   (clk),
    .we    (tag_we),
    .waddr (pick),
    .wdata (blk),
    .raddr (raddr),
    .rdata (rd_tag)
  );

  assign in_oob    = {1'b0, s_tdata[BW-1:0]} >= (BW+1)'(bplru_pkg::NUM_BLOCKS);
  assign accept    = s_tvalid && s_tready;
  assign scan_last = (idx == CW'(NUM_SLOTS)) && p_valid;
  assign out_free  = !m_tvalid || m_tready;
  assign finish    = (state == bplru_pkg::S_FINISH) && out_free;
  assign is_alloc  = (cmd == bplru_pkg::CMD_ALLOC);
  assign cur_valid = slot_valid[p_idx];
  assign aged      = (cur_valid && is_alloc && (rd_age != {AGE_WIDTH{1'b1}}))
                     ? rd_age + AGE_WIDTH'(1) : rd_age;
  assign pick      = found_free ? free_idx : best_idx;
  assign raddr     = idx[IW-1:0];
  assign evict_dirty = !found_free && slot_dirty[best_idx];

  always_comb begin
    state_next = state;
    unique case (state)
      bplru_pkg::S_IDLE: begin
        if (accept) begin
          state_next = in_oob ? bplru_pkg::S_FINISH : bplru_pkg::S_SCAN;
        end
      end
      bplru_pkg::S_SCAN: begin
        if (scan_last) begin
          state_next = bplru_pkg::S_FINISH;
        end
      end
      bplru_pkg::S_FINISH: begin
        if (out_free) begin
          state_next = bplru_pkg::S_IDLE;
        end
      end
      default: state_next = bplru_pkg::S_IDLE;
    endcase
  end

  always_comb begin
    s_tready  = (state == bplru_pkg::S_IDLE);
    age_we    = 1'b0;
    age_waddr = p_idx;
    age_wdata = aged;
    tag_we    = 1'b0;
    if ((state == bplru_pkg::S_SCAN) && p_valid && is_alloc && cur_valid) begin
      age_we = 1'b1;
    end
    if (finish && !oob && is_alloc) begin
      age_we    = 1'b1;
      age_waddr = pick;
      age_wdata = '0;
      tag_we    = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= bplru_pkg::S_IDLE;
      slot_valid <= '0;
      slot_dirty <= '0;
      m_tvalid   <= 1'b0;
      p_valid    <= 1'b0;
    end else begin
      state <= state_next;
      if (finish) begin
        m_tvalid <= 1'b1;
      end else if (m_tready) begin
        m_tvalid <= 1'b0;
      end
      unique case (state)
        bplru_pkg::S_IDLE: begin
          cmd        <= s_tuser;
          blk        <= s_tdata[BW-1:0];
          oob        <= in_oob;
          idx        <= '0;
          p_valid    <= 1'b0;
          found_free <= 1'b0;
          hit        <= 1'b0;
        end
        bplru_pkg::S_SCAN: begin
          // issue the next read, process the slot read last cycle
          p_valid <= (idx != CW'(NUM_SLOTS));
          p_idx   <= idx[IW-1:0];
          if (idx != CW'(NUM_SLOTS)) begin
            idx <= idx + CW'(1);
          end
          if (p_valid) begin
            if (!cur_valid && !found_free) begin
              found_free <= 1'b1;
              free_idx   <= p_idx;
            end
            if (cur_valid && ((p_idx == '0) || (aged > best_age))) begin
              best_age <= aged;
              best_idx <= p_idx;
              best_tag <= rd_tag;
            end
            if (cur_valid && (rd_tag == blk) && !hit) begin
              hit     <= 1'b1;
              hit_idx <= p_idx;
            end
          end
        end
        bplru_pkg::S_FINISH: begin
          if (out_free) begin
            priority if (oob) begin
              out_status <= bplru_pkg::ST_OOB;
              out_slot   <= '0;
              out_wb     <= 1'b0;
              out_wb_blk <= '0;
            end else if (is_alloc) begin
              out_status        <= bplru_pkg::ST_OK;
              out_slot          <= bplru_pkg::SLOT_W'(pick);
              out_wb            <= evict_dirty;
              out_wb_blk        <= evict_dirty ? best_tag : '0;
              slot_valid[pick]  <= 1'b1;
              slot_dirty[pick]  <= 1'b0;
            end else if (hit) begin
              out_status <= bplru_pkg::ST_OK;
              out_slot   <= bplru_pkg::SLOT_W'(hit_idx);
              out_wb     <= 1'b0;
              out_wb_blk <= '0;
              if (cmd == bplru_pkg::CMD_DIRTY) begin
                slot_dirty[hit_idx] <= 1'b1;
              end
            end else begin
              out_status <= bplru_pkg::ST_NOT_HELD;
              out_slot   <= '0;
              out_wb     <= 1'b0;
              out_wb_blk <= '0;
            end
          end
        end
        default: begin
        end
      endcase
    end
  end

  assign m_tdata = {3'b000, out_wb_blk, out_wb, out_slot, out_status};

  `ASSERT_NOW(a_fail_slot_zero, m_tvalid && (out_status != bplru_pkg::ST_OK), out_slot == '0)
  `ASSERT_NOW(a_wb_on_alloc_only, m_tvalid && out_wb, out_status == bplru_pkg::ST_OK)
  `ASSERT_NEXT(a_busy_after_accept, accept, !s_tready)
  `ASSERT_NOW(a_scan_bound, state == bplru_pkg::S_SCAN, idx <= CW'(NUM_SLOTS))

endmodule
